/* sv/lsbsd_pkg.sv */
// Shared types and codes for the LSB stego stream decoder.
// No dependencies; imported by lsbsd_step, lsb_stego_stream_decoder and the testbench.
package lsbsd_pkg;

	localparam int VALUE_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// decode phases
	localparam logic [2:0] PH_HEADER     = 3'd0;
	localparam logic [2:0] PH_MAGIC      = 3'd1;
	localparam logic [2:0] PH_EXT_LEN    = 3'd2;
	localparam logic [2:0] PH_EXT_BYTES  = 3'd3;
	localparam logic [2:0] PH_DATA_LEN   = 3'd4;
	localparam logic [2:0] PH_DATA_BYTES = 3'd5;
	localparam logic [2:0] PH_IDLE       = 3'd6;

	// result kinds
	localparam logic [2:0] KIND_MISMATCH  = 3'd0;
	localparam logic [2:0] KIND_EXT_LEN   = 3'd1;
	localparam logic [2:0] KIND_EXT_BYTE  = 3'd2;
	localparam logic [2:0] KIND_DATA_LEN  = 3'd3;
	localparam logic [2:0] KIND_DATA_BYTE = 3'd4;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SKIP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC_BYTES = 2'd2;

	localparam logic [15:0] HEADER_SKIP_RST = 16'd54;
	localparam logic [1:0]  MAGIC_LEN_RST   = 2'd2;
	localparam logic [15:0] MAGIC_BYTES_RST = 16'h2323;

	typedef struct packed {
		logic [2:0]         kind;
		logic [VALUE_W-1:0] value;
		logic               last;
	} lsbsd_res_t;

endpackage

/* sv/lsbsd_step.sv */
// Next-state and result logic for one image byte of the stego decoder.
// Purely combinational; depends on lsbsd_pkg.
module lsbsd_step import lsbsd_pkg::*; #(
	parameter int LENGTH_BITS = 32,
	parameter int CNT_W = $clog2(LENGTH_BITS)
) (
	input  logic [15:0]            header_skip,
	input  logic [1:0]             magic_len,
	input  logic [15:0]            magic_bytes,
	input  logic                   frame_start,
	input  logic                   pixel_bit,
	input  logic [2:0]             phase,
	input  logic [15:0]            header_count,
	input  logic [CNT_W-1:0]       bit_count,
	input  logic [LENGTH_BITS-1:0] bit_acc,
	input  logic [LENGTH_BITS-1:0] remaining,
	input  logic [1:0]             magic_index,
	output logic [2:0]             phase_nx,
	output logic [15:0]            header_count_nx,
	output logic [CNT_W-1:0]       bit_count_nx,
	output logic [LENGTH_BITS-1:0] bit_acc_nx,
	output logic [LENGTH_BITS-1:0] remaining_nx,
	output logic [1:0]             magic_index_nx,
	output logic                   push,
	output lsbsd_res_t             res
);

	localparam logic [CNT_W-1:0] BYTE_END = CNT_W'(7);
	localparam logic [CNT_W-1:0] LEN_END  = CNT_W'(LENGTH_BITS - 1);

	logic [1:0]             eff_len;
	logic [LENGTH_BITS-1:0] acc_sh;
	logic [7:0]             exp_byte;
	logic [LENGTH_BITS-1:0] rem_dec;
	logic                   active;

	always_comb begin
		eff_len = (magic_len == 2'd3) ? 2'd2 : magic_len;
		phase_nx = phase;
		header_count_nx = header_count;
		bit_count_nx = bit_count;
		bit_acc_nx = bit_acc;
		remaining_nx = remaining;
		magic_index_nx = magic_index;
		push = 1'b0;
		res = '0;
		active = 1'b1;

		if (frame_start) begin
			phase_nx = PH_HEADER;
			header_count_nx = '0;
			bit_count_nx = '0;
			bit_acc_nx = '0;
			remaining_nx = '0;
			magic_index_nx = '0;
		end

		if (phase_nx == PH_HEADER) begin
			if (header_count_nx < header_skip) begin
				header_count_nx = header_count_nx + 16'd1;
				active = 1'b0;
			end else begin
				phase_nx = PH_MAGIC;
				magic_index_nx = '0;
				bit_count_nx = '0;
				bit_acc_nx = '0;
			end
		end

		if (phase_nx == PH_MAGIC && magic_index_nx >= eff_len) begin
			phase_nx = PH_EXT_LEN;
			bit_count_nx = '0;
			bit_acc_nx = '0;
		end

		acc_sh = {bit_acc_nx[LENGTH_BITS-2:0], pixel_bit};
		exp_byte = (magic_index_nx == 2'd0) ? magic_bytes[15:8] : magic_bytes[7:0];
		rem_dec = remaining_nx - LENGTH_BITS'(1);

		if (active) begin
			unique case (phase_nx)
				PH_MAGIC: begin
					if (bit_count_nx >= BYTE_END) begin
						bit_count_nx = '0;
						bit_acc_nx = '0;
						if (acc_sh[7:0] != exp_byte) begin
							phase_nx = PH_IDLE;
							push = 1'b1;
							res.kind = KIND_MISMATCH;
							res.last = 1'b1;
						end else begin
							magic_index_nx = magic_index_nx + 2'd1;
							if (magic_index_nx >= eff_len)
								phase_nx = PH_EXT_LEN;
						end
					end else begin
						bit_count_nx = bit_count_nx + CNT_W'(1);
						bit_acc_nx = acc_sh;
					end
				end
				PH_EXT_LEN, PH_DATA_LEN: begin
					if (bit_count_nx >= LEN_END) begin
						bit_count_nx = '0;
						bit_acc_nx = '0;
						remaining_nx = acc_sh;
						push = 1'b1;
						res.value = VALUE_W'(acc_sh);
						if (phase_nx == PH_EXT_LEN) begin
							res.kind = KIND_EXT_LEN;
							phase_nx = (acc_sh == '0) ? PH_DATA_LEN : PH_EXT_BYTES;
						end else begin
							res.kind = KIND_DATA_LEN;
							res.last = (acc_sh == '0);
							phase_nx = (acc_sh == '0) ? PH_IDLE : PH_DATA_BYTES;
						end
					end else begin
						bit_count_nx = bit_count_nx + CNT_W'(1);
						bit_acc_nx = acc_sh;
					end
				end
				PH_EXT_BYTES, PH_DATA_BYTES: begin
					if (bit_count_nx >= BYTE_END) begin
						bit_count_nx = '0;
						bit_acc_nx = '0;
						remaining_nx = rem_dec;
						push = 1'b1;
						res.value = VALUE_W'(acc_sh[7:0]);
						if (phase_nx == PH_EXT_BYTES) begin
							res.kind = KIND_EXT_BYTE;
							if (rem_dec == '0)
								phase_nx = PH_DATA_LEN;
						end else begin
							res.kind = KIND_DATA_BYTE;
							res.last = (rem_dec == '0);
							if (rem_dec == '0)
								phase_nx = PH_IDLE;
						end
					end else begin
						bit_count_nx = bit_count_nx + CNT_W'(1);
						bit_acc_nx = acc_sh;
					end
				end
				default: begin
					phase_nx = PH_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/lsb_stego_stream_decoder.sv */
// Top level of the LSB stego stream decoder: config registers, decode state,
// output register with skid stage. Depends on lsbsd_pkg and lsbsd_step.
//
// Usage:
//  - Input channel (in_valid/in_ready): one image byte per transaction, with
//    frame_start marking byte 0 of a new image. Only pixel_byte[0] is used.
//  - Output channel (out_valid/out_ready): typed results (kind, value, last);
//    an input byte gives zero or one result.
//  - Config channel (cfg_valid/cfg_ready): cfg_index selects header_skip,
//    magic_len or magic_bytes; cfg_ready is always high. Write only while idle.
//  - Throughput: one byte per cycle. The decode step is a single pass of
//    logic from the state registers into the output register.
//  - Output: the result of the byte that completes it is registered into the
//    output register, or into the skid when the output register is full and not read.
//  - Stall: a result that waits moves into a one-entry skid register, so the
//    block keeps taking bytes; in_ready drops only while the skid is full.
//  - Reset: registers return to their defaults (skip 54, two magic bytes
//    0x2323), decode restarts in header skip, and output/skid are emptied.
//    Bytes before the first frame_start are decoded as a frame that begins
//    at reset.
module lsb_stego_stream_decoder import lsbsd_pkg::*; #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  frame_start,
	input  logic [7:0]            pixel_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            kind,
	output logic [VALUE_W-1:0]    value,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(LENGTH_BITS);

	// configuration
	logic [15:0] header_skip_q;
	logic [1:0]  magic_len_q;
	logic [15:0] magic_bytes_q;

	// decode state
	logic [2:0]             phase_q;
	logic [15:0]            header_count_q;
	logic [CNT_W-1:0]       bit_count_q;
	logic [LENGTH_BITS-1:0] bit_acc_q;
	logic [LENGTH_BITS-1:0] remaining_q;
	logic [1:0]             magic_index_q;

	logic [2:0]             phase_nx;
	logic [15:0]            header_count_nx;
	logic [CNT_W-1:0]       bit_count_nx;
	logic [LENGTH_BITS-1:0] bit_acc_nx;
	logic [LENGTH_BITS-1:0] remaining_nx;
	logic [1:0]             magic_index_nx;
	logic                   push_w;
	lsbsd_res_t             res_w;

	// output register plus skid
	logic       out_valid_q;
	lsbsd_res_t out_q;
	logic       skid_valid_q;
	lsbsd_res_t skid_q;

	logic in_acc;
	logic out_pop;
	logic push_acc;

	assign cfg_ready = 1'b1;
	assign in_ready = ~skid_valid_q;
	assign in_acc = in_valid & in_ready;
	assign out_pop = out_valid_q & out_ready;
	assign push_acc = in_acc & push_w;

	assign out_valid = out_valid_q;
	assign kind = out_q.kind;
	assign value = out_q.value;
	assign last = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_skip_q <= HEADER_SKIP_RST;
			magic_len_q <= MAGIC_LEN_RST;
			magic_bytes_q <= MAGIC_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HEADER_SKIP: header_skip_q <= cfg_data;
				REG_MAGIC_LEN:   magic_len_q <= cfg_data[1:0];
				REG_MAGIC_BYTES: magic_bytes_q <= cfg_data;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	lsbsd_step #(
		.LENGTH_BITS(LENGTH_BITS),
		.CNT_W(CNT_W)
	) u_step (
		.header_skip(header_skip_q),
		.magic_len(magic_len_q),
		.magic_bytes(magic_bytes_q),
		.frame_start(frame_start),
		.pixel_bit(pixel_byte[0]),
		.phase(phase_q),
		.header_count(header_count_q),
		.bit_count(bit_count_q),
		.bit_acc(bit_acc_q),
		.remaining(remaining_q),
		.magic_index(magic_index_q),
		.phase_nx(phase_nx),
		.header_count_nx(header_count_nx),
		.bit_count_nx(bit_count_nx),
		.bit_acc_nx(bit_acc_nx),
		.remaining_nx(remaining_nx),
		.magic_index_nx(magic_index_nx),
		.push(push_w),
		.res(res_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			header_count_q <= '0;
			bit_count_q <= '0;
			bit_acc_q <= '0;
			remaining_q <= '0;
			magic_index_q <= '0;
		end else if (in_acc) begin
			phase_q <= phase_nx;
			header_count_q <= header_count_nx;
			bit_count_q <= bit_count_nx;
			bit_acc_q <= bit_acc_nx;
			remaining_q <= remaining_nx;
			magic_index_q <= magic_index_nx;
		end
	end

	// Output side: skid drains first; a new result lands in the output
	// register when it frees up this cycle, otherwise in the skid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_pop)
				skid_valid_q <= 1'b0;
		end else if (push_acc) begin
			if (out_valid_q && !out_pop)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_pop)
				out_q <= skid_q;
		end else if (push_acc) begin
			if (out_valid_q && !out_pop)
				skid_q <= res_w;
			else
				out_q <= res_w;
		end
	end

	// skid only fills behind an occupied output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while output register is empty");

	// a final result always leaves the decoder idle
	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push_acc && res_w.last |=> phase_q == PH_IDLE)
		else $error("last result did not leave decoder idle");

	// bytes counted off as header never produce a result
	a_header_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !frame_start && phase_q == PH_HEADER
			&& header_count_q < header_skip_q |-> !push_w)
		else $error("result produced during header skip");

	// idle bytes without a restart produce nothing
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !frame_start && phase_q == PH_IDLE |-> !push_w)
		else $error("result produced while idle");

endmodule

/* sim/tb_lsb_stego_stream_decoder.sv */
`timescale 1ns / 100ps
// Self-checking testbench for lsb_stego_stream_decoder: builds hidden-payload frames,
// predicts every typed result and checks it. Depends on lsbsd_pkg and the decoder RTL.
module tb_lsb_stego_stream_decoder import lsbsd_pkg::*;;

	localparam int LEN_BITS       = 32;
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, fills output + skid
	localparam int SETTLE_CYCLES  = 4;     // settle time after the last result, output register plus skid
	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction on any channel
	localparam int NO_LIMIT       = 1 << 30;
	localparam int RAND_BYTES     = 150;

	// Bit-exact predictor of the decoder plus the queue of results it still owes.
	class stego_scoreboard;
		logic [15:0] skip_reg;
		logic [1:0]  mlen_reg;
		logic [15:0] magic_reg;

		logic [2:0]  phase;
		logic [15:0] hdr_cnt;
		logic [4:0]  bit_cnt;
		logic [31:0] shift_reg;
		logic [31:0] bytes_left;
		logic [1:0]  magic_idx;

		lsbsd_res_t  pending_q[$];
		int          errors;
		int          predicted;
		int          checked;
		int          mismatch_frames;

		function new();
			skip_reg  = HEADER_SKIP_RST;
			mlen_reg  = MAGIC_LEN_RST;
			magic_reg = MAGIC_BYTES_RST;
			errors = 0;
			predicted = 0;
			checked = 0;
			mismatch_frames = 0;
			clear_decode();
		endfunction

		function void clear_decode();
			phase      = PH_HEADER;
			hdr_cnt    = '0;
			bit_cnt    = '0;
			shift_reg  = '0;
			bytes_left = '0;
			magic_idx  = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_HEADER_SKIP: skip_reg = data;
				REG_MAGIC_LEN:   mlen_reg = data[1:0];
				REG_MAGIC_BYTES: magic_reg = data;
				default: ;
			endcase
		endfunction

		// shift one hidden bit in, MSB first; true once width bits are collected
		function bit shift_bit(bit b, int unsigned width);
			shift_reg = {shift_reg[30:0], b};
			if (int'(bit_cnt) + 1 >= width) begin
				bit_cnt = '0;
				return 1'b1;
			end
			bit_cnt = bit_cnt + 5'd1;
			return 1'b0;
		endfunction

		function void push(logic [2:0] k, logic [31:0] v, logic l);
			lsbsd_res_t r;
			r.kind  = k;
			r.value = v;
			r.last  = l;
			pending_q.push_back(r);
			predicted++;
			if (k == KIND_MISMATCH)
				mismatch_frames++;
		endfunction

		// one accepted image byte
		function void take_pixel(bit fs, logic [7:0] pix);
			bit          b;
			logic [31:0] v;
			logic [1:0]  eff_len;
			logic [31:0] len_mask;
			b = pix[0];
			len_mask = 32'((64'd1 << LEN_BITS) - 64'd1);
			if (fs)
				clear_decode();
			if (phase == PH_HEADER) begin
				if (hdr_cnt < skip_reg) begin
					hdr_cnt = hdr_cnt + 16'd1;
					return;
				end
				phase = PH_MAGIC;
				magic_idx = '0;
				bit_cnt = '0;
				shift_reg = '0;
			end
			// magic length three acts as two
			eff_len = (mlen_reg > 2'd2) ? 2'd2 : mlen_reg;
			if (phase == PH_MAGIC && magic_idx >= eff_len) begin
				phase = PH_EXT_LEN;
				bit_cnt = '0;
				shift_reg = '0;
			end
			case (phase)
				PH_MAGIC: begin
					if (!shift_bit(b, 8))
						return;
					v = shift_reg & 32'hFF;
					shift_reg = '0;
					if (v[7:0] != ((magic_idx == 2'd0) ? magic_reg[15:8] : magic_reg[7:0])) begin
						phase = PH_IDLE;
						push(KIND_MISMATCH, 32'd0, 1'b1);
						return;
					end
					magic_idx = magic_idx + 2'd1;
					if (magic_idx >= eff_len)
						phase = PH_EXT_LEN;
				end
				PH_EXT_LEN, PH_DATA_LEN: begin
					if (!shift_bit(b, LEN_BITS))
						return;
					v = shift_reg & len_mask;
					shift_reg = '0;
					bytes_left = v;
					if (phase == PH_EXT_LEN) begin
						phase = (v == 0) ? PH_DATA_LEN : PH_EXT_BYTES;
						push(KIND_EXT_LEN, v, 1'b0);
					end else begin
						phase = (v == 0) ? PH_IDLE : PH_DATA_BYTES;
						push(KIND_DATA_LEN, v, v == 0);
					end
				end
				PH_EXT_BYTES, PH_DATA_BYTES: begin
					if (!shift_bit(b, 8))
						return;
					v = shift_reg & 32'hFF;
					shift_reg = '0;
					bytes_left = bytes_left - 32'd1;
					if (phase == PH_EXT_BYTES) begin
						if (bytes_left == 0)
							phase = PH_DATA_LEN;
						push(KIND_EXT_BYTE, v, 1'b0);
					end else begin
						if (bytes_left == 0)
							phase = PH_IDLE;
						push(KIND_DATA_BYTE, v, bytes_left == 0);
					end
				end
				default: phase = PH_IDLE;
			endcase
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 100)
				$display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		// compare one output transaction with the oldest prediction
		task check_result(logic [2:0] k, logic [31:0] v, logic l);
			lsbsd_res_t want;
			checked++;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0d value=0x%08h last=%0b",
					k, v, l));
				return;
			end
			want = pending_q.pop_front();
			if (k !== want.kind)
				report_mismatch($sformatf("result %0d kind %0d, want %0d", checked, k, want.kind));
			if (v !== want.value)
				report_mismatch($sformatf("result %0d value 0x%08h, want 0x%08h",
					checked, v, want.value));
			if (l !== want.last)
				report_mismatch($sformatf("result %0d last %0b, want %0b", checked, l, want.last));
		endtask
	endclass

	// DUT signals; everything starts at a known value
	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic                  frame_start = 1'b0;
	logic [7:0]            pixel_byte  = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [2:0]            kind;
	logic [VALUE_W-1:0]    value;
	logic                  last;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	stego_scoreboard sb;

	// stimulus state
	bit          start_next;      // frame_start goes on the next frame byte
	int          frame_left;      // bytes left before a frame is cut short
	bit          src_burst;       // sender runs back to back
	bit          snk_burst;       // receiver takes every result at once
	bit          long_hold_req;   // ask the receiver for one long hold-off
	int          bytes_sent;
	int          frames_sent;
	int          cfg_phases;
	logic [15:0] cur_skip  = HEADER_SKIP_RST;
	logic [1:0]  cur_mlen  = MAGIC_LEN_RST;
	logic [15:0] cur_magic = MAGIC_BYTES_RST;

	lsb_stego_stream_decoder #(
		.LENGTH_BITS(LEN_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.frame_start(frame_start),
		.pixel_byte(pixel_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.value(value),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// One input transaction. Valid stays up across back-to-back bytes; it only
	// drops when the sender draws a gap. The caller is always on a clock edge.
	task send_pixel(bit fs, logic [7:0] pix);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		frame_start <= fs;
		pixel_byte  <= pix;
		do @(posedge clk); while (!in_ready);
		sb.take_pixel(fs, pix);
		bytes_sent++;
	endtask

	// one hidden bit inside a frame; upper pixel bits are random filler
	task frame_bit(bit b);
		logic [7:0] pix;
		if (frame_left == 0)
			return;
		frame_left--;
		pix = 8'($urandom);
		pix[0] = b;
		send_pixel(start_next, pix);
		start_next = 1'b0;
	endtask

	task frame_bits(logic [31:0] val, int n);
		for (int i = n - 1; i >= 0; i--)
			frame_bit(val[i]);
	endtask

	task frame_noise(int n);
		repeat (n) frame_bit(1'($urandom_range(0, 1)));
	endtask

	// Header bytes, magic, extension length and bytes, data length and bytes,
	// then a few trailing bytes that the block should ignore. Payload is
	// capped at 64 bytes per section so huge lengths end in a truncated frame.
	task send_frame(bit with_start, int hdr, logic [15:0] magic, int nmagic,
			logic [31:0] ext_len, logic [31:0] data_len, int limit);
		int ext_cnt;
		int data_cnt;
		ext_cnt  = (ext_len > 64) ? 64 : int'(ext_len);
		data_cnt = (data_len > 64) ? 64 : int'(data_len);
		start_next = with_start;
		frame_left = limit;
		frames_sent++;
		frame_noise(hdr);
		for (int i = 0; i < nmagic; i++)
			frame_bits({24'd0, (i == 0) ? magic[15:8] : magic[7:0]}, 8);
		frame_bits(ext_len, LEN_BITS);
		repeat (ext_cnt) frame_noise(8);
		frame_bits(data_len, LEN_BITS);
		repeat (data_cnt) frame_noise(8);
		frame_noise($urandom_range(0, 6));
		start_next = 1'b0;
	endtask

	// writes all three registers in one burst; valid stays high between them
	task set_config(logic [15:0] skip, logic [1:0] mlen, logic [15:0] magic);
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		cfg_valid <= 1'b1;
		for (int r = 0; r < 3; r++) begin
			case (r)
				0: begin idx = REG_HEADER_SKIP; data = skip; end
				1: begin idx = REG_MAGIC_LEN;   data = {14'd0, mlen}; end
				default: begin idx = REG_MAGIC_BYTES; data = magic; end
			endcase
			cfg_index <= idx;
			cfg_data  <= data;
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idx, data);
		end
		cfg_valid <= 1'b0;
		cur_skip  = skip;
		cur_mlen  = mlen;
		cur_magic = magic;
		cfg_phases++;
	endtask

	// sender stops until every predicted result is back, then lets the
	// pipeline settle so a register write cannot race a late result
	task drain();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random frame under the current registers: mostly well formed with random
	// payload, the rest broken magic, cut-off frames or raw noise.
	task random_frame();
		int          sel;
		int          nm;
		int          limit;
		logic [15:0] mg;
		logic [31:0] ext_len;
		logic [31:0] data_len;
		sel      = $urandom_range(0, 9);
		nm       = (cur_mlen > 2'd2) ? 2 : int'(cur_mlen);
		mg       = cur_magic;
		ext_len  = $urandom_range(0, 3);
		data_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 8);
		limit    = NO_LIMIT;
		src_burst = ($urandom_range(0, 3) == 0);
		case (sel)
			7: begin
				// broken magic, or a wild length when there is no magic
				if (nm > 0)
					mg = mg ^ (16'd1 << $urandom_range(16 - 8 * nm, 15));
				else
					ext_len = $urandom;
			end
			8: begin
				// frame cut short by the next frame_start
				if ($urandom_range(0, 1) == 1)
					ext_len = $urandom;
				if ($urandom_range(0, 1) == 1)
					data_len = $urandom;
				limit = $urandom_range(0, int'(cur_skip) + 8 * nm + 120);
			end
			default: ;
		endcase
		if (sel == 9) begin
			repeat ($urandom_range(1, 40))
				send_pixel($urandom_range(0, 7) == 0, 8'($urandom));
		end else begin
			send_frame(1'b1, int'(cur_skip), mg, nm, ext_len, data_len, limit);
		end
	endtask

	// Receiver: random gaps, bursts with no gaps, and one long hold-off on
	// request so the output register and skid fill and in_ready drops.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				gap = snk_burst ? 0 : $urandom_range(0, 12);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(kind, value, last);
			if ($urandom_range(0, 39) == 0)
				snk_burst = !snk_burst;
		end
	end

	// Watchdog: a correct run never goes this long without a transaction.
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] watchdog: no transaction for %0d cycles, %0d results outstanding",
			$time, WATCHDOG_LIMIT, sb.pending_q.size());
		$display("Verification failed");
		$finish;
	end

	initial begin
		int rand_bytes0;
		sb = new();
		bytes_sent = 0;
		frames_sent = 0;
		cfg_phases = 0;
		src_burst = 1'b0;
		snk_burst = 1'b0;
		long_hold_req = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// bytes before any frame_start form a frame under the reset registers
		send_frame(1'b0, 54, MAGIC_BYTES_RST, 2, 32'd1, 32'd2, NO_LIMIT);

		// no header, magic check off, both lengths zero: last on data length
		drain();
		set_config(16'd0, 2'd0, 16'h0000);
		send_frame(1'b1, 0, 16'h0000, 0, 32'd0, 32'd0, NO_LIMIT);

		// magic length three acts as two; then a miss on each magic byte
		drain();
		set_config(16'd1, 2'd3, 16'hFFFF);
		send_frame(1'b1, 1, 16'hFFFF, 2, 32'd2, 32'd3, NO_LIMIT);
		send_frame(1'b1, 1, 16'h7FFF, 2, 32'd1, 32'd1, NO_LIMIT);
		send_frame(1'b1, 1, 16'hFFFE, 2, 32'd1, 32'd1, NO_LIMIT);

		// single magic byte; all-ones lengths cut off by the next frame,
		// then a restart in the middle of the header
		drain();
		set_config(16'd2, 2'd1, 16'hA55A);
		send_frame(1'b1, 2, 16'hA55A, 1, 32'hFFFF_FFFF, 32'd0, 2 + 8 + 32 + 40);
		send_frame(1'b1, 2, 16'hA55A, 1, 32'd0, 32'hFFFF_FFFF, 2 + 8 + 64 + 24);
		send_frame(1'b1, 2, 16'hA55A, 1, 32'd3, 32'd4, 1);
		send_frame(1'b1, 2, 16'hA55A, 1, 32'd1, 32'd1, NO_LIMIT);

		// largest header skip: a short frame stays silent inside the header
		drain();
		set_config(16'hFFFF, 2'd2, 16'h0000);
		src_burst = 1'b1;
		send_frame(1'b1, 65535, 16'h0000, 2, 32'd0, 32'd1, 40);

		// back-pressure: a data payload at full rate while the receiver
		// holds off, so the block has to stall its input
		drain();
		set_config(16'd0, 2'd0, 16'h2323);
		long_hold_req = 1'b1;
		send_frame(1'b1, 0, 16'h0000, 0, 32'd0, 32'd16, NO_LIMIT);
		src_burst = 1'b0;

		// --- random: new registers per phase, a few frames each ---
		rand_bytes0 = bytes_sent;
		while ((bytes_sent - rand_bytes0) < RAND_BYTES) begin
			drain();
			case ($urandom_range(0, 7))
				0: set_config(16'd0, 2'($urandom_range(0, 3)), 16'($urandom));
				1: set_config(HEADER_SKIP_RST, 2'($urandom_range(0, 3)), 16'($urandom));
				default: set_config(16'($urandom_range(1, 12)), 2'($urandom_range(0, 3)),
					16'($urandom));
			endcase
			repeat ($urandom_range(2, 4)) random_frame();
		end

		drain();
		src_burst = 1'b0;

		$display("Sent %0d image bytes in %0d frames over %0d register settings.",
			bytes_sent, frames_sent, cfg_phases);
		$display("Checked %0d results (%0d magic misses), %0d field errors.",
			sb.checked, sb.mismatch_frames, sb.errors);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
